### rtl/sda_pkg.sv
// shared types, widths and defaults of the stochastic dendrite automaton
`default_nettype none
package sda_pkg;

    localparam int DEF_BOARD_WIDTH  = 128;
    localparam int DEF_BOARD_HEIGHT = 64;
    localparam int DEF_RANDOM_MAX   = 32767;

    localparam int CMD_W = 2;
    localparam int ROW_W = 6;
    localparam int COL_W = 7;
    localparam int RND_W = 15;
    localparam int NBR_W = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_EVAL  = 2'd2,
        CMD_SNAP  = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROW,
        ST_COPY,
        ST_NB1,
        ST_NB2,
        ST_MUL1,
        ST_MUL2,
        ST_DEC,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic nb_first;
        logic nb_mid;
        logic nb_last;
        logic mul_a;
        logic mul_b;
    } t_eval_ctrl;

endpackage
`default_nettype wire

### rtl/sda_if.sv
// item channels of the automaton: command in, cell result out
`default_nettype none
interface sda_in_if;
    logic                       valid;
    logic                       ready;
    logic [sda_pkg::CMD_W-1:0]  command;
    logic [sda_pkg::ROW_W-1:0]  row;
    logic [sda_pkg::COL_W-1:0]  column;
    logic                       cell_value;
    logic [sda_pkg::RND_W-1:0]  random_value;

    modport source (output valid, command, row, column, cell_value, random_value,
                    input ready);
    modport sink   (input valid, command, row, column, cell_value, random_value,
                    output ready);
endinterface

interface sda_out_if;
    logic valid;
    logic ready;
    logic cell_state;
    logic cell_changed;

    modport source (output valid, cell_state, cell_changed, input ready);
    modport sink   (input valid, cell_state, cell_changed, output ready);
endinterface
`default_nettype wire

### rtl/sda_row_mem.sv
// row-wide board memory, one write and one registered read port, per-row valid bits
`default_nettype none
module sda_row_mem #(
    parameter int DEPTH = sda_pkg::DEF_BOARD_HEIGHT,
    parameter int WIDTH = sda_pkg::DEF_BOARD_WIDTH,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [WIDTH-1:0] r_rd_data;
    logic             r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // a row never written reads as all cells dead
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule
`default_nettype wire

### rtl/sda_eval.sv
// neighbour count and growth decision for one interior cell
`default_nettype none
module sda_eval #(
    parameter int BOARD_WIDTH  = sda_pkg::DEF_BOARD_WIDTH,
    parameter int BOARD_HEIGHT = sda_pkg::DEF_BOARD_HEIGHT,
    parameter int RANDOM_MAX   = sda_pkg::DEF_RANDOM_MAX,
    localparam int COL_AW      = $clog2(BOARD_WIDTH)
) (
    input  wire logic                      i_clk,
    input  wire sda_pkg::t_eval_ctrl       i_ctrl,
    input  wire logic [BOARD_WIDTH-1:0]    i_snap_row,
    input  wire logic [COL_AW-1:0]         i_col,
    input  wire logic [sda_pkg::ROW_W-1:0] i_row,
    input  wire logic [sda_pkg::RND_W-1:0] i_rnd,
    input  wire logic                      i_cur,
    output logic                           o_next
);

    localparam int NBR_W     = sda_pkg::NBR_W;
    localparam int RND_W     = sda_pkg::RND_W;
    localparam int NR_W      = NBR_W + sda_pkg::ROW_W;
    localparam int LHS_SCALE = 8 * BOARD_HEIGHT;
    localparam int LHS_W     = RND_W + $clog2(LHS_SCALE + 1);
    localparam int RM_W      = $clog2(RANDOM_MAX + 1);
    localparam int RHS_W     = NR_W + RM_W;
    localparam int CMP_W     = (LHS_W > RHS_W) ? LHS_W : RHS_W;
    localparam int RW        = (RM_W > RND_W) ? RM_W : RND_W;

    logic [COL_AW-1:0] col_m;
    logic [COL_AW-1:0] col_p;
    logic [2:0]        win;
    logic [NBR_W-1:0]  sum3;
    logic [NBR_W-1:0]  sum2;
    logic [NBR_W-1:0]  r_cnt;
    logic [NR_W-1:0]   r_nr;
    logic [LHS_W-1:0]  r_lhs;
    logic [RHS_W-1:0]  r_rhs;
    logic              born;
    logic              dies;

    assign col_m = i_col - COL_AW'(1);
    assign col_p = i_col + COL_AW'(1);
    assign win   = {i_snap_row[col_p], i_snap_row[i_col], i_snap_row[col_m]};
    assign sum3  = NBR_W'(win[0]) + NBR_W'(win[1]) + NBR_W'(win[2]);
    // own cell is not a neighbour on the middle row
    assign sum2  = NBR_W'(win[0]) + NBR_W'(win[2]);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.nb_first) begin
            r_cnt <= sum3;
        end else if (i_ctrl.nb_mid) begin
            r_cnt <= r_cnt + sum2;
        end else if (i_ctrl.nb_last) begin
            r_cnt <= r_cnt + sum3;
        end
        if (i_ctrl.mul_a) begin
            r_nr  <= NR_W'(r_cnt) * NR_W'(i_row);
            r_lhs <= LHS_W'(i_rnd) * LHS_W'(LHS_SCALE);
        end
        if (i_ctrl.mul_b) begin
            r_rhs <= RHS_W'(r_nr) * RHS_W'(RANDOM_MAX);
        end
    end

    // birth: rnd * 8 * height < n * row * random_max
    assign born   = CMP_W'(r_lhs) < CMP_W'(r_rhs);
    assign dies   = (r_cnt == '0) && (RW'(i_rnd) < RW'(RANDOM_MAX));
    assign o_next = i_cur ? !dies : born;

endmodule
`default_nettype wire

### rtl/stochastic_dendrite_automaton_top.sv
// stochastic dendrite automaton: live board and snapshot in two row memories
// write and read pass through ST_ROW and ST_DONE; evaluate adds ST_NB1 to ST_DEC between them
// (not on a border cell); snapshot adds ST_COPY, one row per cycle through the live read port
// one item is worked at a time; the result register frees the input while it waits
// synchronous active-low reset clears control state and the per-row valid bits,
// so both boards read as all dead at once with no clearing pass
`default_nettype none
module stochastic_dendrite_automaton_top #(
    parameter int BOARD_WIDTH  = sda_pkg::DEF_BOARD_WIDTH,
    parameter int BOARD_HEIGHT = sda_pkg::DEF_BOARD_HEIGHT,
    parameter int RANDOM_MAX   = sda_pkg::DEF_RANDOM_MAX
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sda_in_if.sink     i_in,
    sda_out_if.source  o_out
);

    localparam int ROW_AW = $clog2(BOARD_HEIGHT);
    localparam int COL_AW = $clog2(BOARD_WIDTH);
    localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(BOARD_HEIGHT - 1);

    sda_pkg::t_state  r_state;
    sda_pkg::t_state  n_state;
    sda_pkg::t_cmd    r_cmd;
    logic [sda_pkg::ROW_W-1:0] r_row;
    logic [sda_pkg::COL_W-1:0] r_col;
    logic                      r_val;
    logic [sda_pkg::RND_W-1:0] r_rnd;
    logic                      r_on_board;
    logic                      r_interior;
    logic [ROW_AW-1:0]         r_cp;
    logic                      r_res_state;
    logic                      r_res_changed;
    logic                      r_out_valid;
    logic                      r_out_state;
    logic                      r_out_changed;

    logic                     in_acc;
    logic                     in_ready;
    logic                     out_load;
    logic [ROW_AW-1:0]        row_idx;
    logic [COL_AW-1:0]        col_idx;
    logic                     live_rd_en;
    logic [ROW_AW-1:0]        live_rd_addr;
    logic [BOARD_WIDTH-1:0]   live_rd_data;
    logic                     live_wr_en;
    logic [BOARD_WIDTH-1:0]   live_wr_data;
    logic                     snap_rd_en;
    logic [ROW_AW-1:0]        snap_rd_addr;
    logic [BOARD_WIDTH-1:0]   snap_rd_data;
    logic                     snap_wr_en;
    logic                     wr_bit;
    logic                     cur_bit;
    logic                     eval_next;
    sda_pkg::t_eval_ctrl      eval_ctrl;

    assign in_acc  = i_in.valid && in_ready;
    assign row_idx = ROW_AW'(r_row);
    assign col_idx = COL_AW'(r_col);
    assign cur_bit = live_rd_data[col_idx];

    // live row read data holds from ST_ROW to ST_DEC: no other live read in between
    sda_row_mem #(
        .DEPTH (BOARD_HEIGHT),
        .WIDTH (BOARD_WIDTH)
    ) u_live (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (live_wr_en),
        .i_wr_addr (row_idx),
        .i_wr_data (live_wr_data),
        .i_rd_en   (live_rd_en),
        .i_rd_addr (live_rd_addr),
        .o_rd_data (live_rd_data)
    );

    sda_row_mem #(
        .DEPTH (BOARD_HEIGHT),
        .WIDTH (BOARD_WIDTH)
    ) u_snap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (snap_wr_en),
        .i_wr_addr (r_cp),
        .i_wr_data (live_rd_data),
        .i_rd_en   (snap_rd_en),
        .i_rd_addr (snap_rd_addr),
        .o_rd_data (snap_rd_data)
    );

    sda_eval #(
        .BOARD_WIDTH  (BOARD_WIDTH),
        .BOARD_HEIGHT (BOARD_HEIGHT),
        .RANDOM_MAX   (RANDOM_MAX)
    ) u_eval (
        .i_clk      (i_clk),
        .i_ctrl     (eval_ctrl),
        .i_snap_row (snap_rd_data),
        .i_col      (col_idx),
        .i_row      (r_row),
        .i_rnd      (r_rnd),
        .i_cur      (cur_bit),
        .o_next     (eval_next)
    );

    // read-modify-write of one live row
    assign wr_bit = (r_state == sda_pkg::ST_DEC) ? eval_next : r_val;
    always_comb begin
        live_wr_data          = live_rd_data;
        live_wr_data[col_idx] = wr_bit;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sda_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = sda_pkg::ST_ROW;
                end
            end
            sda_pkg::ST_ROW: begin
                case (r_cmd)
                    sda_pkg::CMD_SNAP: n_state = sda_pkg::ST_COPY;
                    sda_pkg::CMD_EVAL: begin
                        n_state = r_interior ? sda_pkg::ST_NB1 : sda_pkg::ST_DONE;
                    end
                    default:           n_state = sda_pkg::ST_DONE;
                endcase
            end
            sda_pkg::ST_COPY: begin
                if (r_cp == LAST_ROW) begin
                    n_state = sda_pkg::ST_DONE;
                end
            end
            sda_pkg::ST_NB1:  n_state = sda_pkg::ST_NB2;
            sda_pkg::ST_NB2:  n_state = sda_pkg::ST_MUL1;
            sda_pkg::ST_MUL1: n_state = sda_pkg::ST_MUL2;
            sda_pkg::ST_MUL2: n_state = sda_pkg::ST_DEC;
            sda_pkg::ST_DEC:  n_state = sda_pkg::ST_DONE;
            sda_pkg::ST_DONE: begin
                if (out_load) begin
                    n_state = sda_pkg::ST_IDLE;
                end
            end
            default: n_state = sda_pkg::ST_IDLE;
        endcase
    end

    // state outputs: memory ports, eval steps, handshakes
    always_comb begin
        in_ready     = 1'b0;
        out_load     = 1'b0;
        live_rd_en   = 1'b0;
        live_rd_addr = ROW_AW'(i_in.row);
        live_wr_en   = 1'b0;
        snap_rd_en   = 1'b0;
        snap_rd_addr = ROW_AW'(i_in.row) - ROW_AW'(1);
        snap_wr_en   = 1'b0;
        eval_ctrl    = '0;
        case (r_state)
            sda_pkg::ST_IDLE: begin
                in_ready   = 1'b1;
                live_rd_en = i_in.valid;
                snap_rd_en = i_in.valid;
            end
            sda_pkg::ST_ROW: begin
                case (r_cmd)
                    sda_pkg::CMD_WRITE: live_wr_en = r_on_board;
                    sda_pkg::CMD_SNAP: begin
                        live_rd_en   = 1'b1;
                        live_rd_addr = '0;
                    end
                    sda_pkg::CMD_EVAL: begin
                        eval_ctrl.nb_first = 1'b1;
                        snap_rd_en         = 1'b1;
                        snap_rd_addr       = row_idx;
                    end
                    default: ;
                endcase
            end
            sda_pkg::ST_COPY: begin
                snap_wr_en   = 1'b1;
                live_rd_en   = (r_cp != LAST_ROW);
                live_rd_addr = r_cp + ROW_AW'(1);
            end
            sda_pkg::ST_NB1: begin
                eval_ctrl.nb_mid = 1'b1;
                snap_rd_en       = 1'b1;
                snap_rd_addr     = row_idx + ROW_AW'(1);
            end
            sda_pkg::ST_NB2:  eval_ctrl.nb_last = 1'b1;
            sda_pkg::ST_MUL1: eval_ctrl.mul_a   = 1'b1;
            sda_pkg::ST_MUL2: eval_ctrl.mul_b   = 1'b1;
            sda_pkg::ST_DEC:  live_wr_en        = 1'b1;
            sda_pkg::ST_DONE: out_load          = !r_out_valid || o_out.ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sda_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd      <= sda_pkg::t_cmd'(i_in.command);
            r_row      <= i_in.row;
            r_col      <= i_in.column;
            r_val      <= i_in.cell_value;
            r_rnd      <= i_in.random_value;
            r_on_board <= (32'(i_in.row) < BOARD_HEIGHT) &&
                          (32'(i_in.column) < BOARD_WIDTH);
            r_interior <= (i_in.row != '0) && (i_in.column != '0) &&
                          (32'(i_in.row) < BOARD_HEIGHT - 1) &&
                          (32'(i_in.column) < BOARD_WIDTH - 1);
        end
        case (r_state)
            sda_pkg::ST_ROW: begin
                r_cp          <= '0;
                r_res_changed <= 1'b0;
                if (r_cmd == sda_pkg::CMD_WRITE) begin
                    r_res_state <= r_on_board & r_val;
                end else begin
                    r_res_state <= r_on_board & cur_bit;
                end
            end
            sda_pkg::ST_COPY: r_cp <= r_cp + ROW_AW'(1);
            sda_pkg::ST_DEC: begin
                r_res_state   <= eval_next;
                r_res_changed <= eval_next ^ cur_bit;
            end
            default: ;
        endcase
        if (out_load) begin
            r_out_state   <= r_res_state;
            r_out_changed <= r_res_changed;
        end
    end

    assign i_in.ready         = in_ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.cell_state   = r_out_state;
    assign o_out.cell_changed = r_out_changed;

`ifndef NO_ASSERTIONS
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == sda_pkg::ST_DONE))
        else $error("result item appeared outside the done step");

    a_accept_to_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == sda_pkg::ST_ROW))
        else $error("accepted item did not start a row read");

    a_copy_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sda_pkg::ST_COPY && r_cp == LAST_ROW) |=>
        (r_state == sda_pkg::ST_DONE))
        else $error("snapshot copy ran past the last row");

    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        live_wr_en |-> (!snap_wr_en && !live_rd_en))
        else $error("live row write overlaps another board access");
`endif

endmodule
`default_nettype wire

### tb/sv/stochastic_dendrite_automaton_top_tb.sv
// testbench of the automaton: cell commands against a board predictor, checked item by item
`timescale 1ns / 1ps
module stochastic_dendrite_automaton_top_tb;

    localparam int BOARD_W   = sda_pkg::DEF_BOARD_WIDTH;
    localparam int BOARD_H   = sda_pkg::DEF_BOARD_HEIGHT;
    localparam int RND_TOP   = sda_pkg::DEF_RANDOM_MAX;
    localparam int ROW_W     = sda_pkg::ROW_W;
    localparam int COL_W     = sda_pkg::COL_W;
    localparam int RND_W     = sda_pkg::RND_W;
    localparam int DRAIN_CYC = BOARD_H + 40;
    localparam int PRINT_CAP = 200;

    typedef struct packed {
        bit state;
        bit changed;
    } t_cell_result;

    logic i_clk;
    logic i_rst_n;

    sda_in_if  u_in_if ();
    sda_out_if u_out_if ();

    stochastic_dendrite_automaton_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (u_in_if),
        .o_out   (u_out_if)
    );

    // predicted boards
    bit [BOARD_W-1:0] live_rows [BOARD_H];
    bit [BOARD_W-1:0] snap_rows [BOARD_H];

    t_cell_result pending_results [$];
    int           mismatch_count;
    int           items_sent;
    bit           idle_on;
    int           hold_request;

    always #5 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP) begin
            $display("%0t mismatch: %s", $time, what);
        end
    endtask

    function automatic t_cell_result apply_cell_command(input sda_pkg::t_cmd cmd,
                                                        input bit [ROW_W-1:0] r,
                                                        input bit [COL_W-1:0] c, input bit v,
                                                        input bit [RND_W-1:0] rnd);
        t_cell_result      res;
        bit                cur;
        bit                nxt;
        int unsigned       nbrs;
        longint unsigned   grow_lhs;
        longint unsigned   grow_rhs;
        res = '0;
        if (cmd == sda_pkg::CMD_SNAP) begin
            snap_rows = live_rows;
        end
        case (cmd)
            sda_pkg::CMD_WRITE: begin
                live_rows[r][c] = v;
            end
            sda_pkg::CMD_EVAL: begin
                // border cells are left as they are
                if (r >= 1 && c >= 1 && r < BOARD_H - 1 && c < BOARD_W - 1) begin
                    nbrs = 0;
                    for (int dr = -1; dr <= 1; dr++) begin
                        for (int dc = -1; dc <= 1; dc++) begin
                            if (dr != 0 || dc != 0) begin
                                nbrs += snap_rows[int'(r) + dr][int'(c) + dc];
                            end
                        end
                    end
                    cur = live_rows[r][c];
                    nxt = cur;
                    if (cur) begin
                        if (nbrs == 0 && rnd < RND_TOP) begin
                            nxt = 1'b0;
                        end
                    end else begin
                        // rnd < (n / 8) * (row / height) * max, cross-multiplied
                        grow_lhs = rnd;
                        grow_lhs = grow_lhs * 8 * BOARD_H;
                        grow_rhs = nbrs;
                        grow_rhs = grow_rhs * r * RND_TOP;
                        if (grow_lhs < grow_rhs) begin
                            nxt = 1'b1;
                        end
                    end
                    live_rows[r][c] = nxt;
                    res.changed = (nxt != cur);
                end
            end
            default: ;
        endcase
        res.state = live_rows[r][c];
        return res;
    endfunction

    task automatic send_cell_command(input sda_pkg::t_cmd cmd, input bit [ROW_W-1:0] r,
                                     input bit [COL_W-1:0] c, input bit v,
                                     input bit [RND_W-1:0] rnd);
        if (idle_on && $urandom_range(99) < 6) begin
            u_in_if.valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        u_in_if.valid        <= 1'b1;
        u_in_if.command      <= cmd;
        u_in_if.row          <= r;
        u_in_if.column       <= c;
        u_in_if.cell_value   <= v;
        u_in_if.random_value <= rnd;
        @(posedge i_clk);
        while (!u_in_if.ready) @(posedge i_clk);
        pending_results.push_back(apply_cell_command(cmd, r, c, v, rnd));
        items_sent++;
    endtask

    // lower valid and wait until every result is back
    task automatic drain_results();
        u_in_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    function automatic bit [RND_W-1:0] pick_random_draw();
        case ($urandom_range(9))
            0:       return '0;
            1:       return RND_W'(RND_TOP);
            2:       return RND_W'(RND_TOP - 1);
            3, 4:    return RND_W'($urandom_range(600));
            default: return RND_W'($urandom_range(RND_TOP));
        endcase
    endfunction

    // receiver: random idling, plus a long hold when asked
    initial begin
        int hold_left;
        hold_left = 0;
        u_out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                u_out_if.ready <= 1'b0;
            end else if (idle_on && $urandom_range(99) < 6) begin
                u_out_if.ready <= 1'b0;
            end else begin
                u_out_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_cell_result exp;
        if (i_rst_n && u_out_if.valid && u_out_if.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no item waiting");
            end else begin
                exp = pending_results.pop_front();
                if (u_out_if.cell_state !== exp.state) begin
                    report_mismatch($sformatf("cell_state exp %0b got %0b",
                                              exp.state, u_out_if.cell_state));
                end
                if (u_out_if.cell_changed !== exp.changed) begin
                    report_mismatch($sformatf("cell_changed exp %0b got %0b",
                                              exp.changed, u_out_if.cell_changed));
                end
            end
        end
    end

    task automatic test_directed_cases();
        send_cell_command(sda_pkg::CMD_READ,  0,   0,   0, 0);
        send_cell_command(sda_pkg::CMD_WRITE, 0,   0,   1, 0);
        send_cell_command(sda_pkg::CMD_WRITE, 63,  127, 1, 0);
        send_cell_command(sda_pkg::CMD_WRITE, 0,   1,   1, 0);
        send_cell_command(sda_pkg::CMD_WRITE, 0,   2,   1, 0);
        send_cell_command(sda_pkg::CMD_WRITE, 5,   5,   1, 0);
        send_cell_command(sda_pkg::CMD_WRITE, 7,   7,   1, 0);
        send_cell_command(sda_pkg::CMD_WRITE, 62,  125, 1, 0);
        send_cell_command(sda_pkg::CMD_WRITE, 63,  126, 1, 0);
        send_cell_command(sda_pkg::CMD_SNAP,  5,   5,   0, 0);
        // border cells of each edge
        send_cell_command(sda_pkg::CMD_EVAL,  0,   5,   0, 0);
        send_cell_command(sda_pkg::CMD_EVAL,  63,  127, 0, 0);
        send_cell_command(sda_pkg::CMD_EVAL,  10,  0,   0, 0);
        send_cell_command(sda_pkg::CMD_EVAL,  10,  127, 0, 0);
        // isolated live cell: dies below the top draw, survives at it
        send_cell_command(sda_pkg::CMD_EVAL,  5,   5,   0, 0);
        send_cell_command(sda_pkg::CMD_EVAL,  7,   7,   0, 15'h7fff);
        // birth threshold on row one with three neighbours, then a cell with two
        send_cell_command(sda_pkg::CMD_EVAL,  1,   1,   0, 191);
        send_cell_command(sda_pkg::CMD_EVAL,  1,   1,   0, 0);
        send_cell_command(sda_pkg::CMD_EVAL,  1,   2,   0, 192);
        // birth threshold near the far corner
        send_cell_command(sda_pkg::CMD_EVAL,  62,  126, 0, 15'h7fff);
        send_cell_command(sda_pkg::CMD_EVAL,  62,  126, 0, 11903);
        send_cell_command(sda_pkg::CMD_WRITE, 63,  127, 0, 15'h7fff);
        send_cell_command(sda_pkg::CMD_READ,  63,  127, 1, 0);
        send_cell_command(sda_pkg::CMD_SNAP,  63,  127, 1, 15'h7fff);
    endtask

    // seed a window, take a snapshot, then sweep evaluations and reads over it
    task automatic test_random_generations(input int target);
        bit [ROW_W-1:0] r0;
        bit [COL_W-1:0] c0;
        while (items_sent < target) begin
            r0 = ROW_W'($urandom_range(BOARD_H - 8));
            c0 = COL_W'($urandom_range(BOARD_W - 8));
            repeat ($urandom_range(12, 2)) begin
                send_cell_command(sda_pkg::CMD_WRITE, r0 + ROW_W'($urandom_range(7)),
                                  c0 + COL_W'($urandom_range(7)),
                                  $urandom_range(9) < 7, pick_random_draw());
            end
            if ($urandom_range(9) == 0) begin
                send_cell_command(sda_pkg::t_cmd'($urandom_range(3)), ROW_W'($urandom),
                                  COL_W'($urandom), 1'($urandom), RND_W'($urandom));
            end
            send_cell_command(sda_pkg::CMD_SNAP, r0 + ROW_W'($urandom_range(7)),
                              c0 + COL_W'($urandom_range(7)), 1'($urandom), RND_W'($urandom));
            repeat ($urandom_range(20, 6)) begin
                send_cell_command($urandom_range(4) == 0 ? sda_pkg::CMD_READ : sda_pkg::CMD_EVAL,
                                  r0 + ROW_W'($urandom_range(7)),
                                  c0 + COL_W'($urandom_range(7)),
                                  1'($urandom), pick_random_draw());
            end
        end
    endtask

    // long output hold while items keep coming, so the input must stall
    task automatic test_output_stall();
        hold_request = 300;
        repeat (30) begin
            send_cell_command(sda_pkg::t_cmd'($urandom_range(2)), ROW_W'($urandom),
                              COL_W'($urandom), 1'($urandom), pick_random_draw());
        end
    endtask

    task automatic test_drain_pause();
        repeat (10) begin
            send_cell_command(sda_pkg::t_cmd'($urandom_range(3)), ROW_W'($urandom),
                              COL_W'($urandom), 1'($urandom), pick_random_draw());
        end
        drain_results();
        test_random_generations(items_sent + 20);
    endtask

    task automatic test_without_idling(input int target);
        idle_on = 1'b0;
        test_random_generations(target);
        idle_on = 1'b1;
    endtask

    initial begin
        i_clk          = 1'b0;
        mismatch_count = 0;
        items_sent     = 0;
        idle_on        = 1'b1;
        hold_request   = 0;
        foreach (live_rows[i]) begin
            live_rows[i] = '0;
            snap_rows[i] = '0;
        end
        i_rst_n              = 1'b0;
        u_in_if.valid        = 1'b0;
        u_in_if.command      = sda_pkg::CMD_WRITE;
        u_in_if.row          = '0;
        u_in_if.column       = '0;
        u_in_if.cell_value   = 1'b0;
        u_in_if.random_value = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_random_generations(600);
        test_output_stall();
        test_drain_pause();
        test_without_idling(900);
        test_random_generations(1400);

        drain_results();
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
